[rtl/core/lamp_sunrise_sunset_ramp_defines.svh]
// ----------------------------------------------------------------------------
// lamp_sunrise_sunset_ramp_defines
// assertion macros shared by the ramp checker
// ----------------------------------------------------------------------------
`ifndef LAMP_SUNRISE_SUNSET_RAMP_DEFINES_SVH
`define LAMP_SUNRISE_SUNSET_RAMP_DEFINES_SVH

// same-cycle implication
`define LSSR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lssr assertion failed");

// next-cycle implication
`define LSSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lssr assertion failed");

`endif

[rtl/core/lssr_pkg.sv]
// ----------------------------------------------------------------------------
// lssr_pkg
// types and constants of the lamp sunrise / sunset ramp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lssr_pkg;

   localparam int LevelWidth    = 8;
   localparam int IntervalWidth = 7;
   localparam int CmdWidth      = 2;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 8;

   typedef logic [LevelWidth-1:0]    level_type;
   typedef logic [IntervalWidth-1:0] interval_type;

   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK  = 2'd0,
      CMD_RISE  = 2'd1,
      CMD_FALL  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_LEVEL     = 3'd0,
      CSR_FULL_LEVEL    = 3'd1,
      CSR_RISE_LEVEL    = 3'd2,
      CSR_PEAK_LEVEL    = 3'd3,
      CSR_FLOOR_LEVEL   = 3'd4,
      CSR_STEP_INTERVAL = 3'd5
   } csr_index_type;

   localparam level_type    MinLevelReset     = 8'd0;
   localparam level_type    FullLevelReset    = 8'd255;
   localparam level_type    RiseLevelReset    = 8'd0;
   localparam level_type    PeakLevelReset    = 8'd255;
   localparam level_type    FloorLevelReset   = 8'd0;
   localparam interval_type StepIntervalReset = 7'd10;

endpackage

`default_nettype wire

[rtl/core/lamp_sunrise_sunset_ramp.sv]
// ----------------------------------------------------------------------------
// lamp_sunrise_sunset_ramp: one lamp channel's fade ramp with pwm drive output
// result: an accepted item's result is registered in the output register on the next clock edge
// throughput: one item per cycle while the response is not stalled, set by the single level/timer update stage
// reset: synchronous, clears flags, timer and output valid, loads register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lamp_sunrise_sunset_ramp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lssr_pkg::CmdWidth-1:0]       req_cmd,
   input  wire logic                                req_skip,
   input  wire logic                                req_paused,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lssr_pkg::LevelWidth-1:0]          rsp_level,
   output logic [lssr_pkg::LevelWidth-1:0]          rsp_pwm_duty,
   output logic                                     rsp_active,
   output logic                                     rsp_falling,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lssr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [lssr_pkg::CsrDataWidth-1:0]   csr_data
);
   import lssr_pkg::*;

   level_type    min_level_ff, full_level_ff, rise_level_ff;
   level_type    peak_level_ff, floor_level_ff;
   interval_type step_interval_ff;

   level_type    level_ff, level_in;
   logic         active_ff, active_in;
   logic         falling_ff, falling_in;
   interval_type tick_ff, tick_in;

   logic         rsp_valid_ff, rsp_valid_in;
   level_type    rsp_level_ff, rsp_pwm_duty_ff;
   logic         rsp_active_ff, rsp_falling_ff;

   logic         accept;
   logic         expired;
   level_type    lift;
   logic [IntervalWidth:0] tick_next;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff     <= MinLevelReset;
         full_level_ff    <= FullLevelReset;
         rise_level_ff    <= RiseLevelReset;
         peak_level_ff    <= PeakLevelReset;
         floor_level_ff   <= FloorLevelReset;
         step_interval_ff <= StepIntervalReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_LEVEL:     min_level_ff     <= csr_data;
            CSR_FULL_LEVEL:    full_level_ff    <= csr_data;
            CSR_RISE_LEVEL:    rise_level_ff    <= csr_data;
            CSR_PEAK_LEVEL:    peak_level_ff    <= csr_data;
            CSR_FLOOR_LEVEL:   floor_level_ff   <= csr_data;
            CSR_STEP_INTERVAL: step_interval_ff <= csr_data[IntervalWidth-1:0];
            default: ;
         endcase
      end
   end

   // interval timer
   assign tick_next = {1'b0, tick_ff} + (IntervalWidth+1)'(1);
   assign expired   = tick_next >= {1'b0, step_interval_ff};
   // rising phase jump
   assign lift      = (level_ff < rise_level_ff) ? rise_level_ff : level_ff;

   always_comb begin
      level_in   = level_ff;
      active_in  = active_ff;
      falling_in = falling_ff;
      tick_in    = tick_ff;
      case (req_cmd)
         CMD_TICK: begin
            if (!req_paused) begin
               if (active_ff) begin
                  tick_in = expired ? '0 : tick_next[IntervalWidth-1:0];
                  if (!falling_ff) begin
                     level_in = (expired && lift < peak_level_ff) ? lift + level_type'(1)
                                                                  : lift;
                  end else begin
                     if (expired && level_ff > floor_level_ff) begin
                        level_in = level_ff - level_type'(1);
                     end
                     if (level_in == floor_level_ff) begin
                        level_in   = min_level_ff;
                        active_in  = 1'b0;
                        falling_in = 1'b0;
                     end
                  end
               end else if (req_skip && level_ff != '0) begin
                  level_in = min_level_ff;
               end
            end
         end
         CMD_RISE: begin
            active_in  = 1'b1;
            falling_in = 1'b0;
            tick_in    = '0;
         end
         CMD_FALL: begin
            if (active_ff) begin
               falling_in = 1'b1;
               tick_in    = '0;
            end
         end
         default: begin
            level_in = min_level_ff;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= MinLevelReset;
         active_ff    <= 1'b0;
         falling_ff   <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            level_ff   <= level_in;
            active_ff  <= active_in;
            falling_ff <= falling_in;
            tick_ff    <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_level_ff    <= level_in;
         rsp_pwm_duty_ff <= full_level_ff - level_in;
         rsp_active_ff   <= active_in;
         rsp_falling_ff  <= falling_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_pwm_duty = rsp_pwm_duty_ff;
   assign rsp_active   = rsp_active_ff;
   assign rsp_falling  = rsp_falling_ff;

endmodule

`default_nettype wire

[rtl/core/lssr_checker.sv]
// ----------------------------------------------------------------------------
// lssr_checker
// port-level checks of the lamp ramp, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lamp_sunrise_sunset_ramp_defines.svh"

module lssr_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic [lssr_pkg::CmdWidth-1:0]       req_cmd,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                rsp_active,
   input  wire logic                                rsp_falling
);
   import lssr_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   `LSSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `LSSR_ASSERT_NEXT(a_item_result, req_fire, rsp_valid)
   `LSSR_ASSERT_NOW(a_falling_active, rsp_valid && rsp_falling, rsp_active)
   `LSSR_ASSERT_NEXT(a_rise_starts, req_fire && req_cmd == CMD_RISE,
      rsp_active && !rsp_falling)

endmodule

bind lamp_sunrise_sunset_ramp lssr_checker u_lssr_checker (.*);

`default_nettype wire
